/* rtl/egoc_pkg.sv */
package egoc_pkg;

	localparam logic [1:0] FUNC_WR  = 2'd0;
	localparam logic [1:0] FUNC_REB = 2'd1;
	localparam logic [1:0] FUNC_QRY = 2'd2;

	localparam logic CFG_UPPER = 1'b0;
	localparam logic CFG_LOWER = 1'b1;

	localparam logic [14:0] DIST_MAX  = 15'h7fff;
	localparam logic [12:0] COUNT_MAX = 13'h1fff;

	typedef struct packed {
		logic load;
		logic pt_wr;
		logic clr_en;
		logic scan_en;
		logic qry_en;
		logic sqrt_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_last;
		logic qry_last;
		logic empty;
		logic pipe_busy;
		logic sqrt_busy;
		logic out_free;
	} sts_t;

endpackage

/* rtl/egoc_ctrl.sv */
module egoc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       func,
	output logic             in_stall,
	input  egoc_pkg::sts_t   sts,
	output egoc_pkg::cmd_t   cmd
);
	import egoc_pkg::*;

	localparam logic [2:0] ST_CLR    = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SCAN   = 3'd2;
	localparam logic [2:0] ST_DRN_S  = 3'd3;
	localparam logic [2:0] ST_QRY    = 3'd4;
	localparam logic [2:0] ST_DRN_Q  = 3'd5;
	localparam logic [2:0] ST_SQRT   = 3'd6;
	localparam logic [2:0] ST_OUT    = 3'd7;

	logic [2:0] state_q, state_d;
	logic       acc;

	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc) begin
					cmd.load = 1'b1;
					case (func)
						FUNC_WR:  cmd.pt_wr = 1'b1;
						FUNC_REB: state_d = ST_SCAN;
						FUNC_QRY: state_d = sts.empty ? ST_OUT : ST_QRY;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_last) state_d = ST_DRN_S;
			end
			ST_DRN_S: begin
				if (!sts.pipe_busy) state_d = ST_OUT;
			end
			ST_QRY: begin
				cmd.qry_en = 1'b1;
				if (sts.qry_last) state_d = ST_DRN_Q;
			end
			ST_DRN_Q: begin
				if (!sts.pipe_busy) begin
					cmd.sqrt_start = 1'b1;
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (!sts.sqrt_busy) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLR;
		else state_q <= state_d;
	end

endmodule

/* rtl/egoc_dp.sv */
module egoc_dp #(
	parameter int GRID_X      = 64,
	parameter int GRID_Y      = 64,
	parameter int HEIGHT_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [15:0]            cfg_data,
	input  logic [1:0]             func,
	input  logic [5:0]             cell_x,
	input  logic [5:0]             cell_y,
	input  logic signed [15:0]     height,
	input  egoc_pkg::cmd_t         cmd,
	output egoc_pkg::sts_t         sts,
	input  logic                   out_stall,
	output logic                   out_valid,
	output logic                   kind,
	output logic [12:0]            obstacle_count,
	output logic [14:0]            distance_q8,
	output logic                   no_obstacle,
	output logic                   clear_ok
);
	import egoc_pkg::*;

	localparam int CELLS = GRID_X * GRID_Y;
	localparam int AW    = $clog2(CELLS);
	localparam int NW    = $clog2(CELLS + 1);
	localparam int XW    = $clog2(GRID_X);
	localparam int YW    = $clog2(GRID_Y);
	localparam int LW    = XW + YW;
	localparam int CW    = (XW > 6) ? ((XW > YW) ? XW : YW) : ((YW > 6) ? YW : 6);
	localparam int D2W   = 2 * CW + 1;
	localparam int SI    = CW + 9;
	localparam int RW    = 2 * SI;
	localparam int RB    = SI + 2;
	localparam int SCW   = $clog2(SI + 1);
	localparam int HB    = HEIGHT_BITS;
	localparam int EW    = ((HB > 16) ? HB : 16) + 1;
	localparam int CMW   = (NW > 13) ? NW : 13;
	localparam logic signed [EW-1:0] HMAX = EW'((64'sd1 <<< (HB - 1)) - 64'sd1);
	localparam logic signed [EW-1:0] HMIN = -HMAX - EW'(1);

	logic signed [15:0] up_q, lo_q;
	logic [AW-1:0]      cnt_q;
	logic [XW-1:0]      sx_q;
	logic [YW-1:0]      sy_q;
	logic [NW-1:0]      n_q;
	logic [CW-1:0]      qx_q, qy_q;
	logic [1:0]         func_q;

	logic signed [HB-1:0] elev_mem [CELLS];
	logic [LW-1:0]        list_mem [CELLS];

	logic signed [HB-1:0] rd_s1;
	logic [XW-1:0]        x_s1;
	logic [YW-1:0]        y_s1;
	logic                 sv_s1;
	logic [LW-1:0]        qd_s1;
	logic                 qv_s1;
	logic [D2W-1:0]       d2_s2;
	logic                 qv_s2;
	logic [D2W-1:0]       best_q;

	logic [RW-1:0]  rad_q;
	logic [RB-1:0]  rem_q;
	logic [SI-1:0]  root_q;
	logic [SCW-1:0] scnt_q;

	logic                 in_grid;
	logic [AW-1:0]        pt_addr;
	logic signed [EW-1:0] h_ext;
	logic signed [HB-1:0] h_sat;
	logic signed [EW-1:0] e_ext;
	logic                 hit;
	logic [CW-1:0]        ox, oy, ax, ay;
	logic [D2W-1:0]       d2;
	logic [RB-1:0]        trial, cand;
	logic [CMW-1:0]       cnt_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q <= '0;
			lo_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_UPPER: up_q <= cfg_data;
				CFG_LOWER: lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_grid = (32'(cell_x) < GRID_X) && (32'(cell_y) < GRID_Y);
	assign pt_addr = AW'(32'(cell_y) * GRID_X + 32'(cell_x));
	assign h_ext   = EW'(height);
	assign h_sat   = (h_ext > HMAX) ? HB'(HMAX) : ((h_ext < HMIN) ? HB'(HMIN) : HB'(h_ext));

	always_ff @(posedge clk) begin
		if (cmd.clr_en) elev_mem[cnt_q] <= '0;
		else if (cmd.pt_wr && in_grid) elev_mem[pt_addr] <= h_sat;
		if (cmd.scan_en) rd_s1 <= elev_mem[cnt_q];
	end

	// counters shared by clear pass, scan and list walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
		end else if (cmd.clr_en || cmd.scan_en || cmd.qry_en) begin
			cnt_q <= cnt_q + AW'(1);
			if (32'(sx_q) == GRID_X - 1) begin
				sx_q <= '0;
				sy_q <= sy_q + YW'(1);
			end else begin
				sx_q <= sx_q + XW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			qx_q   <= CW'(cell_x);
			qy_q   <= CW'(cell_y);
		end
		if (cmd.scan_en) begin
			x_s1 <= sx_q;
			y_s1 <= sy_q;
		end
	end

	assign e_ext = EW'(rd_s1);
	assign hit   = (e_ext > EW'(up_q)) || (e_ext < EW'(lo_q));

	always_ff @(posedge clk) begin
		if (sv_s1 && hit) list_mem[n_q[AW-1:0]] <= {y_s1, x_s1};
		if (cmd.qry_en) qd_s1 <= list_mem[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sv_s1 <= 1'b0;
			qv_s1 <= 1'b0;
			qv_s2 <= 1'b0;
			n_q   <= '0;
		end else begin
			sv_s1 <= cmd.scan_en;
			qv_s1 <= cmd.qry_en;
			qv_s2 <= qv_s1;
			if (cmd.load && func == FUNC_REB) n_q <= '0;
			else if (sv_s1 && hit) n_q <= n_q + NW'(1);
		end
	end

	assign ox = CW'(qd_s1[XW-1:0]);
	assign oy = CW'(qd_s1[LW-1:XW]);
	assign ax = (qx_q >= ox) ? qx_q - ox : ox - qx_q;
	assign ay = (qy_q >= oy) ? qy_q - oy : oy - qy_q;
	assign d2 = D2W'((2*CW)'(ax) * (2*CW)'(ax)) + D2W'((2*CW)'(ay) * (2*CW)'(ay));

	always_ff @(posedge clk) begin
		if (qv_s1) d2_s2 <= d2;
		if (cmd.load) best_q <= '1;
		else if (qv_s2 && d2_s2 < best_q) best_q <= d2_s2;
	end

	// restoring square root, one result bit per cycle
	assign trial = {rem_q[RB-3:0], rad_q[RW-1:RW-2]};
	assign cand  = {root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			rad_q  <= RW'({best_q, 16'b0});
			rem_q  <= '0;
			root_q <= '0;
		end else if (scnt_q != '0) begin
			rad_q <= {rad_q[RW-3:0], 2'b00};
			if (trial >= cand) begin
				rem_q  <= trial - cand;
				root_q <= {root_q[SI-2:0], 1'b1};
			end else begin
				rem_q  <= trial;
				root_q <= {root_q[SI-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scnt_q <= '0;
		else if (cmd.sqrt_start) scnt_q <= SCW'(SI);
		else if (scnt_q != '0) scnt_q <= scnt_q - SCW'(1);
	end

	assign cnt_ext = CMW'(n_q);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (func_q == FUNC_REB) begin
				kind           <= 1'b0;
				obstacle_count <= (cnt_ext > CMW'(COUNT_MAX)) ? COUNT_MAX : 13'(cnt_ext);
				distance_q8    <= '0;
				no_obstacle    <= 1'b0;
				clear_ok       <= 1'b0;
			end else begin
				kind           <= 1'b1;
				obstacle_count <= '0;
				if (n_q == '0) begin
					distance_q8 <= DIST_MAX;
					no_obstacle <= 1'b1;
					clear_ok    <= 1'b1;
				end else begin
					distance_q8 <= (root_q > SI'(DIST_MAX)) ? DIST_MAX : 15'(root_q);
					no_obstacle <= 1'b0;
					clear_ok    <= (best_q != '0);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	assign sts.clr_last  = (32'(cnt_q) == CELLS - 1);
	assign sts.scan_last = (32'(cnt_q) == CELLS - 1);
	assign sts.qry_last  = (cnt_q == AW'(n_q - NW'(1)));
	assign sts.empty     = (n_q == '0);
	assign sts.pipe_busy = sv_s1 || qv_s1 || qv_s2;
	assign sts.sqrt_busy = (scnt_q != '0);
	assign sts.out_free  = !out_valid || !out_stall;

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free) else $error("result overwrites pending transaction");
	a_one_walk: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.scan_en && cmd.qry_en)) else $error("scan and query overlap");
	a_sqrt_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sqrt_start |=> sts.sqrt_busy) else $error("root unit did not start");
	a_list_fit: assert property (@(posedge clk) disable iff (!arst_n)
		(sv_s1 && hit) |-> (32'(n_q) < CELLS)) else $error("obstacle list overflow");

endmodule

/* rtl/elevation_grid_obstacle_clearance.sv */
// Elevation grid with obstacle clearance.
// Input channel (in_valid/in_stall) carries func, cell_x, cell_y, height.
//   func 0 writes a height into a cell (no result), func 1 rebuilds the
//   obstacle list and returns its count, func 2 returns the least distance
//   from the cell to a listed obstacle in Q8 cells. Code 3 is dropped.
// Output channel (out_valid/out_stall) is a single result register; the
//   block keeps working on the next transaction while a result waits, and
//   holds in its output state if a second result is ready before the first
//   is taken.
// One transaction at a time. A write updates one cell and gives no result.
//   A rebuild is paced by the one-cell-per-cycle scan of the elevation memory,
//   a query by the one-entry-per-cycle list walk and the bit-serial square
//   root; a query on an empty list skips both and goes straight to output.
// Reset: thresholds and obstacle count go to zero, then a clearing pass over
//   all GRID_X*GRID_Y cells zeroes the elevation memory; in_stall is high for
//   its length. Configuration writes are taken at any time.
module elevation_grid_obstacle_clearance #(
	parameter int GRID_X      = 64,
	parameter int GRID_Y      = 64,
	parameter int HEIGHT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [5:0]         cell_x,
	input  logic [5:0]         cell_y,
	input  logic signed [15:0] height,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               kind,
	output logic [12:0]        obstacle_count,
	output logic [14:0]        distance_q8,
	output logic               no_obstacle,
	output logic               clear_ok
);
	import egoc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	egoc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	egoc_dp #(
		.GRID_X      (GRID_X),
		.GRID_Y      (GRID_Y),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.func           (func),
		.cell_x         (cell_x),
		.cell_y         (cell_y),
		.height         (height),
		.cmd            (cmd),
		.sts            (sts),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.kind           (kind),
		.obstacle_count (obstacle_count),
		.distance_q8    (distance_q8),
		.no_obstacle    (no_obstacle),
		.clear_ok       (clear_ok)
	);

endmodule

/* sim/elevation_grid_obstacle_clearance_test.sv */
module elevation_grid_obstacle_clearance_test;
	timeunit 1ns;
	timeprecision 1ps;
	import egoc_pkg::*;

	localparam int CELL_COUNT = 4096;
	localparam int STALL_LIMIT = 40000;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [12:0] obstacle_count;
		logic [14:0] distance_q8;
		logic        no_obstacle;
		logic        clear_ok;
	} answer_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] func;
	logic [5:0] cell_x;
	logic [5:0] cell_y;
	logic signed [15:0] height;
	logic out_valid;
	logic out_stall;
	logic kind;
	logic [12:0] obstacle_count;
	logic [14:0] distance_q8;
	logic no_obstacle;
	logic clear_ok;

	elevation_grid_obstacle_clearance u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .func(func),
		.cell_x(cell_x), .cell_y(cell_y), .height(height), .out_valid(out_valid),
		.out_stall(out_stall), .kind(kind), .obstacle_count(obstacle_count),
		.distance_q8(distance_q8), .no_obstacle(no_obstacle), .clear_ok(clear_ok)
	);

	// predictor state
	logic signed [15:0] grid_height [CELL_COUNT];
	logic [5:0] obst_x [CELL_COUNT];
	logic [5:0] obst_y [CELL_COUNT];
	int unsigned obst_total;
	logic signed [15:0] upper_mm;
	logic signed [15:0] lower_mm;

	answer_t pending_answers[$];
	int mismatch_count;
	int answers_seen;
	int idle_cycles;
	int items_sent;
	bit idle_enable;
	bit hold_receiver;
	int hold_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [14:0] q8_root(input longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return (res > 32767) ? DIST_MAX : res[14:0];
	endfunction

	task automatic predict_item(input logic [1:0] f, input logic [5:0] x, input logic [5:0] y,
			input logic signed [15:0] h);
		answer_t a;
		longint unsigned best;
		longint unsigned d2;
		int dx;
		int dy;
		a = '0;
		if (f == FUNC_WR) begin
			grid_height[{y, x}] = h;
		end else if (f == FUNC_REB) begin
			obst_total = 0;
			for (int i = 0; i < CELL_COUNT; i++) begin
				if (grid_height[i] > upper_mm || grid_height[i] < lower_mm) begin
					obst_x[obst_total] = i[5:0];
					obst_y[obst_total] = i[11:6];
					obst_total++;
				end
			end
			a.obstacle_count = 13'(obst_total);
			pending_answers = {pending_answers, a};
		end else if (f == FUNC_QRY) begin
			a.kind = 1'b1;
			if (obst_total == 0) begin
				a.distance_q8 = DIST_MAX;
				a.no_obstacle = 1'b1;
				a.clear_ok = 1'b1;
			end else begin
				best = 64'hffff_ffff_ffff_ffff;
				for (int i = 0; i < obst_total; i++) begin
					dx = int'(x) - int'(obst_x[i]);
					dy = int'(y) - int'(obst_y[i]);
					d2 = 64'(dx * dx + dy * dy);
					if (d2 < best) best = d2;
				end
				a.distance_q8 = q8_root(best << 16);
				a.clear_ok = best > 0;
			end
			pending_answers = {pending_answers, a};
		end
	endtask

	task automatic send_item(input logic [1:0] f, input logic [5:0] x, input logic [5:0] y,
			input logic signed [15:0] h);
		while (idle_enable && $urandom_range(99) < 29) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		func <= f;
		cell_x <= x;
		cell_y <= y;
		height <= h;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_item(f, x, y, h);
		items_sent++;
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// Waits out the result queue plus the slowest possible query walk.
	task automatic wait_drained();
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (CELL_COUNT + 64) @(negedge clk);
	endtask

	task automatic write_thresholds(input logic signed [15:0] up, input logic signed [15:0] lo);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= CFG_UPPER;
		cfg_data <= up;
		@(negedge clk);
		cfg_index <= CFG_LOWER;
		cfg_data <= lo;
		@(negedge clk);
		cfg_we <= 1'b0;
		upper_mm = up;
		lower_mm = lo;
	endtask

	task automatic send_random_query();
		send_item(FUNC_QRY, 6'($urandom), 6'($urandom), 16'($urandom));
	endtask

	task automatic test_empty_grid();
		send_item(FUNC_QRY, 6'd0, 6'd0, 16'sd0);
		send_item(FUNC_REB, 6'd5, 6'd9, 16'sd0);
		send_item(FUNC_QRY, 6'd63, 6'd63, 16'sd0);
		send_item(FUNC_NONE, 6'd1, 6'd1, 16'sd100);
	endtask

	task automatic test_directed_extremes();
		write_thresholds(16'sd100, -16'sd100);
		send_item(FUNC_WR, 6'd0, 6'd0, 16'sh7fff);
		send_item(FUNC_WR, 6'd63, 6'd63, -16'sh8000);
		send_item(FUNC_WR, 6'd10, 6'd20, 16'sd100);
		send_item(FUNC_WR, 6'd11, 6'd20, -16'sd100);
		send_item(FUNC_WR, 6'd12, 6'd20, 16'sd101);
		send_item(FUNC_WR, 6'd12, 6'd20, 16'sd50);
		send_item(FUNC_NONE, 6'd30, 6'd30, 16'sh7fff);
		send_item(FUNC_REB, 6'd0, 6'd0, 16'sd0);
		send_item(FUNC_QRY, 6'd0, 6'd0, 16'sd0);
		send_item(FUNC_QRY, 6'd63, 6'd0, 16'shffff);
		send_item(FUNC_QRY, 6'd31, 6'd32, 16'sd0);
		send_item(FUNC_QRY, 6'd62, 6'd63, 16'sd0);
	endtask

	task automatic test_threshold_extremes();
		write_thresholds(16'sh7fff, -16'sh8000);
		send_item(FUNC_REB, 6'd0, 6'd0, 16'sd0);
		send_item(FUNC_QRY, 6'd7, 6'd7, 16'sd0);
		write_thresholds(-16'sh8000, 16'sh7fff);
		send_item(FUNC_REB, 6'd0, 6'd0, 16'sd0);
		send_item(FUNC_QRY, 6'd7, 6'd7, 16'sd0);
		// tiny list again so later queries stay fast
		write_thresholds(16'sd1000, -16'sd1000);
		send_item(FUNC_REB, 6'd0, 6'd0, 16'sd0);
	endtask

	task automatic test_random_mix(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			idle_enable = !(i >= count / 3 && i < count / 2);
			r = $urandom_range(99);
			if (r < 55) begin
				send_item(FUNC_WR, 6'($urandom), 6'($urandom), 16'($urandom));
			end else if (r < 65) begin
				send_item(FUNC_REB, 6'($urandom), 6'($urandom), 16'($urandom));
			end else if (r < 97) begin
				send_random_query();
			end else begin
				send_item(FUNC_NONE, 6'($urandom), 6'($urandom), 16'($urandom));
			end
		end
		idle_enable = 1'b1;
	endtask

	task automatic test_backpressure();
		hold_cycles = 300;
		hold_receiver = 1'b1;
		for (int i = 0; i < 6; i++) send_random_query();
		wait_drained();
		write_thresholds(16'($urandom_range(2000)),
			-$signed({1'b0, 15'($urandom_range(2000))}));
		send_item(FUNC_REB, 6'd0, 6'd0, 16'sd0);
		for (int i = 0; i < 4; i++) send_random_query();
	endtask

	always @(posedge clk) begin
		answer_t got;
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{kind, obstacle_count, distance_q8, no_obstacle, clear_ok};
			answers_seen++;
			if (pending_answers.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10) $display("unexpected result %p", got);
			end else begin
				want = pending_answers.pop_front();
				if (got !== want) begin
					mismatch_count++;
					if (mismatch_count <= 10) $display("mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (hold_receiver) begin
			out_stall <= 1'b1;
			if (hold_cycles == 0) hold_receiver = 1'b0;
			else hold_cycles--;
		end else begin
			out_stall <= idle_enable && ($urandom_range(99) < 29);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", idle_cycles);
			$display("FAIL elevation_grid_obstacle_clearance");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_UPPER;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_WR;
		cell_x = '0;
		cell_y = '0;
		height = '0;
		out_stall = 1'b0;
		idle_enable = 1'b1;
		hold_receiver = 1'b0;
		hold_cycles = 0;
		mismatch_count = 0;
		answers_seen = 0;
		idle_cycles = 0;
		items_sent = 0;
		obst_total = 0;
		upper_mm = 0;
		lower_mm = 0;
		for (int i = 0; i < CELL_COUNT; i++) grid_height[i] = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_empty_grid();
		test_directed_extremes();
		test_threshold_extremes();
		test_random_mix(110);
		test_backpressure();
		wait_drained();

		$display("covered %0d input transactions and %0d results, thresholds at both extremes,",
			items_sent, answers_seen);
		$display("stalls on both channels and a long receiver hold-off");
		if (mismatch_count == 0 && pending_answers.size() == 0) begin
			$display("PASS elevation_grid_obstacle_clearance");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatch_count,
				pending_answers.size());
			$display("FAIL elevation_grid_obstacle_clearance");
		end
		$finish;
	end
endmodule
